// ===== src/msrng_pkg.sv =====
// ----------------------------------------------------------------------------
// Multi-stream random generator package
// Shared constants, opcodes and the per-stream word bundle.
// ----------------------------------------------------------------------------
package msrng_pkg;

  // Default number of streams held in the bank.
  localparam int unsigned NumStreamsDefault = 8;

  // Field widths fixed by the item format.
  localparam int unsigned OpW     = 3;
  localparam int unsigned StreamW = 3;
  localparam int unsigned WordW   = 32;

  // Highest number of streams the stream field can address.
  localparam int unsigned MaxAddressable = 1 << StreamW;

  // Generator constants.
  localparam logic [WordW-1:0] LcgMul    = 32'd69069;
  localparam logic [WordW-1:0] LcgAdd    = 32'd1013904243;
  localparam logic [WordW-1:0] SwbOffset = 32'd18;

  // Default words of every stream.
  localparam logic [WordW-1:0] DefLagA     = 32'd521288629;
  localparam logic [WordW-1:0] DefLagB     = 32'd362436069;
  localparam logic [WordW-1:0] DefLagC     = 32'd1613801;
  localparam logic [WordW-1:0] DefBorrow   = 32'd1;
  localparam logic [WordW-1:0] DefPosition = 32'd1131199209;

  // Operation codes carried with each item.
  typedef enum logic [OpW-1:0] {
    OP_NEXT   = 3'd0,
    OP_LOAD   = 3'd1,
    OP_SETPOS = 3'd2,
    OP_RESET  = 3'd3,
    OP_READ   = 3'd4
  } op_e;

  // The five words that make up one stream's state.
  typedef struct packed {
    logic [WordW-1:0] lag_a;
    logic [WordW-1:0] lag_b;
    logic [WordW-1:0] lag_c;
    logic [WordW-1:0] borrow;
    logic [WordW-1:0] position;
  } words_t;

  localparam words_t DefWords = '{
    lag_a:    DefLagA,
    lag_b:    DefLagB,
    lag_c:    DefLagC,
    borrow:   DefBorrow,
    position: DefPosition
  };

endpackage

// ===== src/msrng_step.sv =====
// ----------------------------------------------------------------------------
// Multi-stream random generator step
// Applies one operation to one stream's words and forms the random number.
// ----------------------------------------------------------------------------
module msrng_step (
  input  logic [msrng_pkg::OpW-1:0]   op_i,
  input  msrng_pkg::words_t           cur_i,
  input  msrng_pkg::words_t           load_i,
  output msrng_pkg::words_t           nxt_o,
  output logic [msrng_pkg::WordW-1:0] rand_o
);

  logic [msrng_pkg::WordW-1:0] sum_t;
  logic [msrng_pkg::WordW-1:0] swb_s;
  logic                        swb_borrow;
  logic [msrng_pkg::WordW-1:0] lcg_p;
  msrng_pkg::words_t           adv;

  // Subtract-with-borrow step; the borrow word joins the sum at full width.
  always_comb begin
    sum_t = cur_i.lag_a + cur_i.borrow;
    if (cur_i.lag_b > sum_t) begin
      swb_s      = cur_i.lag_b - sum_t;
      swb_borrow = 1'b0;
    end else begin
      swb_s      = sum_t - cur_i.lag_b - msrng_pkg::SwbOffset;
      swb_borrow = 1'b1;
    end
  end

  // Congruential update, constant multiply modulo 2^32.
  assign lcg_p = cur_i.position * msrng_pkg::LcgMul + msrng_pkg::LcgAdd;

  // Words after an advance: lags shift down, the new lag enters at the top.
  always_comb begin
    adv.lag_a    = cur_i.lag_b;
    adv.lag_b    = cur_i.lag_c;
    adv.lag_c    = swb_s;
    adv.borrow   = {{(msrng_pkg::WordW-1){1'b0}}, swb_borrow};
    adv.position = lcg_p;
  end

  // Select the new words and the random number by operation.
  always_comb begin
    nxt_o  = cur_i;
    rand_o = '0;
    case (msrng_pkg::op_e'(op_i))
      msrng_pkg::OP_NEXT: begin
        nxt_o  = adv;
        rand_o = swb_s + lcg_p;
      end
      msrng_pkg::OP_LOAD: begin
        nxt_o = load_i;
      end
      msrng_pkg::OP_SETPOS: begin
        nxt_o.position = load_i.position;
      end
      msrng_pkg::OP_RESET: begin
        nxt_o = msrng_pkg::DefWords;
      end
      default: begin
        // Read and unused codes leave the stream unchanged.
        nxt_o = cur_i;
      end
    endcase
  end

endmodule

// ===== src/multi_stream_swb_lcg_rng_unit.sv =====
// ----------------------------------------------------------------------------
// Multi-stream random generator
// Bank of independent subtract-with-borrow plus congruential streams.
// ----------------------------------------------------------------------------
// Each item passes through the input register, then the result register, before its
// result can be taken. Throughput: one item per cycle while the result side is not
// stalled, including items to the same stream back to back; the bank write and the
// result register update at the same edge. Reset sets every stream to its default
// words at once and empties both registers.
module multi_stream_swb_lcg_rng_unit #(
  parameter int unsigned NUM_STREAMS = msrng_pkg::NumStreamsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Input items.
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // new_lag_a, new_lag_b, new_lag_c, new_borrow, new_position
  input  logic [159:0] s_axis_tdata_i,
  // opcode, stream
  input  logic [5:0]   s_axis_tuser_i,
  // Result items.
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // rand_value, stored_lag_a, stored_lag_b, stored_lag_c, stored_borrow,
  // stored_position
  output logic [191:0] m_axis_tdata_o
);

  localparam int unsigned W = msrng_pkg::WordW;
  // Streams beyond what the stream field can address are never reached.
  localparam int unsigned NumBanks = (NUM_STREAMS < msrng_pkg::MaxAddressable) ?
                                     NUM_STREAMS : msrng_pkg::MaxAddressable;
  localparam int unsigned IdxW = (NumBanks > 1) ? $clog2(NumBanks) : 1;
  localparam logic [msrng_pkg::StreamW:0] NumBanksL = (msrng_pkg::StreamW+1)'(NumBanks);

  // Input register.
  logic                            in_valid_q;
  logic [msrng_pkg::OpW-1:0]       in_op_q;
  logic [msrng_pkg::StreamW-1:0]   in_stream_q;
  msrng_pkg::words_t               in_load_q;

  // Result register.
  logic                            out_valid_q;
  logic [W-1:0]                    out_rand_q;
  msrng_pkg::words_t               out_words_q;

  // Stream bank.
  msrng_pkg::words_t               bank_q [NumBanks];

  logic                            advance;
  logic                            fire;
  logic                            stream_ok;
  logic [IdxW-1:0]                 idx;
  msrng_pkg::words_t               cur;
  msrng_pkg::words_t               nxt;
  logic [W-1:0]                    rand_val;

  // The result register moves when empty or when its item is taken.
  assign advance         = !out_valid_q || m_axis_tready_i;
  assign fire            = in_valid_q && advance;
  assign s_axis_tready_o = !in_valid_q || advance;

  // Stream selection; an out-of-range stream yields an all-zero result.
  assign stream_ok = {1'b0, in_stream_q} < NumBanksL;
  assign idx       = in_stream_q[IdxW-1:0];
  assign cur       = stream_ok ? bank_q[idx] : msrng_pkg::DefWords;

  msrng_step u_step (
    .op_i   (in_op_q),
    .cur_i  (cur),
    .load_i (in_load_q),
    .nxt_o  (nxt),
    .rand_o (rand_val)
  );

  // Input register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_op_q            <= s_axis_tuser_i[2:0];
      in_stream_q        <= s_axis_tuser_i[5:3];
      in_load_q.lag_a    <= s_axis_tdata_i[31:0];
      in_load_q.lag_b    <= s_axis_tdata_i[63:32];
      in_load_q.lag_c    <= s_axis_tdata_i[95:64];
      in_load_q.borrow   <= s_axis_tdata_i[127:96];
      in_load_q.position <= s_axis_tdata_i[159:128];
    end
  end

  // Result register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_rand_q  <= stream_ok ? rand_val : '0;
      out_words_q <= stream_ok ? nxt : '0;
    end
  end

  // Stream bank: defaults on reset, written back as each in-range item completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumBanks; i++) begin
        bank_q[i] <= msrng_pkg::DefWords;
      end
    end else if (fire && stream_ok) begin
      bank_q[idx] <= nxt;
    end
  end

  // Output packing, first field in the lowest bits.
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_words_q.position, out_words_q.borrow,
                            out_words_q.lag_c, out_words_q.lag_b,
                            out_words_q.lag_a, out_rand_q};

endmodule

// ===== src/msrng_checker.sv =====
// ----------------------------------------------------------------------------
// Multi-stream random generator checker
// Port-level properties of the unit, attached to the top level by bind.
// ----------------------------------------------------------------------------
module msrng_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid_i,
  input logic         s_axis_tready_o,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [191:0] m_axis_tdata_o
);

  // A stalled result item holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("Stalled result item changed.");

  // The input side only stalls when a result item is waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("Input stalled with an empty result register.");

  // A result appearing from empty comes from an accepted input item, through the input and result registers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(s_axis_tvalid_i && s_axis_tready_o, 2))
    else $error("Result item appeared without an accepted input item.");

  // A result item only leaves through a handshake.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(m_axis_tvalid_o) |-> $past(m_axis_tready_i))
    else $error("Result item dropped without being taken.");

endmodule

bind multi_stream_swb_lcg_rng_unit msrng_checker u_msrng_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
